// ===== src/droplet_photon_placer_top_assert.svh =====
// ----------------------------------------------------------------------------
// droplet photon placer assertion macros
// concurrent check macros, compiled away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DROPLET_PHOTON_PLACER_TOP_ASSERT_SVH
`define DROPLET_PHOTON_PLACER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DPP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DPP_ASSERT(lbl, prop, msg)
`define DPP_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// shared types and constants of the droplet photon placer
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int PIXELS_DEF      = 65536;
  localparam int MAX_PHOTONS_DEF = 64;

  localparam logic signed [31:0] ADU_FLOOR = -32'sd100000000;
  localparam logic [15:0]        APP_RESET = 16'd1;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DROP  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic walk_rd;
    logic walk_cmp;
    logic upd_rd;
    logic upd_wr;
    logic cnt_rd;
    logic rd_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       in_valid;
    logic [1:0] kind;
    logic       ok;
    logic       zero_n;
    logic       walk_end;
    logic       last_photon;
    logic       out_free;
  } st_t;

endpackage

// ===== src/dpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpp_ctrl
// sequencer: clearing pass, item decode, walk, update and result hand-off
// ----------------------------------------------------------------------------
module dpp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  dpp_pkg::st_t  st,
  output dpp_pkg::cmd_t cmd,
  output logic          in_ready
);
  import dpp_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_WALK_RD = 8'b0000_0100,
    S_WALK_CMP= 8'b0000_1000,
    S_UPD_RD  = 8'b0001_0000,
    S_UPD_WR  = 8'b0010_0000,
    S_CNT_RD  = 8'b0100_0000,
    S_CNT_OUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.accept = 1'b1;
          if (st.kind == KIND_DROP && st.ok && !st.zero_n) state_nxt = S_WALK_RD;
          else if (st.kind == KIND_READ) state_nxt = S_CNT_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        cmd.walk_cmp = 1'b1;
        state_nxt    = st.walk_end ? S_UPD_RD : S_WALK_RD;
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UPD_WR;
      end
      S_UPD_WR: begin
        // keep reading the chosen pixel while the result register is busy
        cmd.upd_rd = 1'b1;
        if (st.out_free) begin
          cmd.upd_wr = 1'b1;
          state_nxt  = st.last_photon ? S_IDLE : S_WALK_RD;
        end
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_CNT_OUT;
      end
      S_CNT_OUT: begin
        cmd.cnt_rd = 1'b1;
        if (st.out_free) begin
          cmd.rd_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== src/dpp_datapath.sv =====
// ----------------------------------------------------------------------------
// dpp_datapath
// pixel memories, walk registers, update arithmetic and result register
// ----------------------------------------------------------------------------
module dpp_datapath #(
  parameter int PIXELS      = dpp_pkg::PIXELS_DEF,
  parameter int MAX_PHOTONS = dpp_pkg::MAX_PHOTONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dpp_pkg::cmd_t cmd,
  output dpp_pkg::st_t  st,
  input  logic          in_valid,
  input  logic [1:0]    in_kind,
  input  logic [15:0]   in_pix,
  input  logic [31:0]   in_adu,
  input  logic [15:0]   in_next,
  input  logic [6:0]    in_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_has,
  output logic [15:0]   out_pix,
  output logic [7:0]    out_cnt,
  output logic          out_last
);
  import dpp_pkg::*;

  localparam int DEPTH = (PIXELS < 65536) ? PIXELS : 65536;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(PIXELS + 1);

  logic signed [31:0] adu_mem [0:DEPTH-1];
  logic [15:0]        link_mem [0:DEPTH-1];
  logic [7:0]         cnt_mem [0:DEPTH-1];

  logic [15:0]        app_r;
  logic [AW-1:0]      clr_r;
  logic [15:0]        start_r, pos_r, best_r;
  logic signed [31:0] top_r;
  logic [SW-1:0]      steps_r;
  logic [6:0]         n_r, k_r;
  logic               ok_r;
  logic               out_valid_r, out_has_r, out_last_r;
  logic [15:0]        out_pix_r;
  logic [7:0]         out_cnt_r;

  logic [AW-1:0]      rd_addr;
  logic signed [31:0] adu_q;
  logic [15:0]        link_q;
  logic [7:0]         cnt_q;

  logic               in_ok, load_we;
  logic [6:0]         n_sat;
  logic [SW-1:0]      steps_nxt;
  logic               link_bad;
  logic signed [32:0] diff;
  logic signed [31:0] adu_new;
  logic [7:0]         cnt_new;

  assign in_ok   = ({16'd0, in_pix} < 32'(PIXELS));
  assign n_sat   = (32'(in_n) > 32'(MAX_PHOTONS)) ? 7'(MAX_PHOTONS) : in_n;
  assign load_we = cmd.accept && in_kind == KIND_LOAD && in_ok;

  assign steps_nxt = steps_r + SW'(1);
  assign link_bad  = !({16'd0, link_q} < 32'(PIXELS));

  assign diff    = {adu_q[31], adu_q} - $signed({17'd0, app_r});
  assign adu_new = (diff[32] != diff[31]) ? 32'sh8000_0000 : diff[31:0];
  assign cnt_new = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;

  always_comb begin
    rd_addr = '0;
    if (cmd.walk_rd) rd_addr = pos_r[AW-1:0];
    else if (cmd.upd_rd) rd_addr = best_r[AW-1:0];
    else if (cmd.cnt_rd) rd_addr = start_r[AW-1:0];
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (load_we) begin
      adu_mem[in_pix[AW-1:0]]  <= in_adu;
      link_mem[in_pix[AW-1:0]] <= in_next;
    end else if (cmd.upd_wr) begin
      adu_mem[best_r[AW-1:0]] <= adu_new;
    end
    adu_q  <= adu_mem[rd_addr];
    link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) cnt_mem[clr_r] <= 8'd0;
    else if (load_we) cnt_mem[in_pix[AW-1:0]] <= 8'd0;
    else if (cmd.upd_wr) cnt_mem[best_r[AW-1:0]] <= cnt_new;
    cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      app_r       <= APP_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) app_r <= cfg_wdata;
      if (cmd.clr) clr_r <= clr_r + AW'(1);
      if (cmd.upd_wr || cmd.rd_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      start_r <= in_pix;
      pos_r   <= in_pix;
      best_r  <= in_pix;
      top_r   <= ADU_FLOOR;
      steps_r <= '0;
      n_r     <= n_sat;
      k_r     <= 7'd0;
      ok_r    <= in_ok;
    end
    if (cmd.walk_cmp) begin
      if (adu_q > top_r) begin
        top_r  <= adu_q;
        best_r <= pos_r;
      end
      pos_r   <= link_q;
      steps_r <= steps_nxt;
    end
    if (cmd.upd_wr) begin
      k_r     <= k_r + 7'd1;
      pos_r   <= start_r;
      best_r  <= start_r;
      top_r   <= ADU_FLOOR;
      steps_r <= '0;
    end
    if (cmd.upd_wr) begin
      out_has_r  <= 1'b1;
      out_pix_r  <= best_r;
      out_cnt_r  <= cnt_new;
      out_last_r <= (k_r + 7'd1 == n_r);
    end else if (cmd.rd_out) begin
      out_has_r  <= 1'b0;
      out_pix_r  <= start_r;
      out_cnt_r  <= ok_r ? cnt_q : 8'd0;
      out_last_r <= 1'b1;
    end
  end

  always_comb begin
    st.clr_last    = (32'(clr_r) == DEPTH - 1);
    st.in_valid    = in_valid;
    st.kind        = in_kind;
    st.ok          = in_ok;
    st.zero_n      = (in_n == 7'd0);
    st.walk_end    = link_bad || link_q == start_r || steps_nxt == SW'(PIXELS);
    st.last_photon = (k_r + 7'd1 == n_r);
    st.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_has   = out_has_r;
  assign out_pix   = out_pix_r;
  assign out_cnt   = out_cnt_r;
  assign out_last  = out_last_r;

endmodule

// ===== src/droplet_photon_placer_top.sv =====
// ----------------------------------------------------------------------------
// droplet_photon_placer_top
// places single photons on droplet pixels by repeated maximum search
// ----------------------------------------------------------------------------
// usage:
// - in_ stream: tuser is the item kind (load, droplet, read); tdata packs
//   pixel index, adu value, next index and photon count
// - load transfers write one pixel and clear its count
// - an in-range droplet transfer yields one result per photon (capped at
//   MAX_PHOTONS); each photon walks the droplet list, a memory read and then
//   a compare per pixel, and then updates the chosen pixel (read, then write
//   once the result register is free)
// - a read transfer yields one result, read from the count memory and then registered
// - out_tlast marks the final result of an item, out_tuser is has_photon
// - cfg_ write sets adu_per_photon, taken at any time, used at each pixel update
// - after reset a clearing pass zeroes all min(PIXELS,65536) count memory
//   entries, one pixel per cycle, and in_tready stays low until it ends
// - a stalled receiver holds the result register; the walk stops before its
//   update until the register is free, input is taken again once the final
//   result sits in the register
// ----------------------------------------------------------------------------
`include "droplet_photon_placer_top_assert.svh"

module droplet_photon_placer_top #(
  parameter int PIXELS      = dpp_pkg::PIXELS_DEF,
  parameter int MAX_PHOTONS = dpp_pkg::MAX_PHOTONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // pixel_index, adu_value, next_index, photon_count, pad
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // photon_index, pixel_count
  output logic        out_tuser,  // has_photon
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // adu_per_photon
);
  import dpp_pkg::*;

  cmd_t cmd;
  st_t  st;

  // register writes never stall
  assign cfg_ready = 1'b1;

  dpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  dpp_datapath #(
    .PIXELS      (PIXELS),
    .MAX_PHOTONS (MAX_PHOTONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser),
    .in_pix    (in_tdata[15:0]),
    .in_adu    (in_tdata[47:16]),
    .in_next   (in_tdata[63:48]),
    .in_n      (in_tdata[70:64]),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_has   (out_tuser),
    .out_pix   (out_tdata[15:0]),
    .out_cnt   (out_tdata[23:16]),
    .out_last  (out_tlast)
  );

  // an update only lands in a free result register
  `DPP_ASSERT(a_upd_free, cmd.upd_wr |-> st.out_free, "update with result register busy")
  // no input during the clearing pass
  `DPP_NEVER(a_clr_no_in, cmd.clr && in_tready, "input taken while clearing")
  // every update produces a visible result next cycle
  `DPP_ASSERT(a_upd_out, cmd.upd_wr |=> out_tvalid, "update without result")

endmodule
